@@ hdl/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants for the ray segment versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

    // Default fractional bits of the fixed-point format
    localparam int FRAC_BITS_DEF = 16;
    // Widest supported fraction, sets the quotient field width
    localparam int FRAC_BITS_MAX = 24;
    localparam int QW_MAX        = FRAC_BITS_MAX + 2;
    // Six divider lanes: corner a of x,y,z then corner b of x,y,z
    localparam int NLANE         = 6;
    localparam int NAXIS         = 3;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic signed [31:0] step_z;
        logic signed [31:0] corner_a_x;
        logic signed [31:0] corner_a_y;
        logic signed [31:0] corner_a_z;
        logic signed [31:0] corner_b_x;
        logic signed [31:0] corner_b_y;
        logic signed [31:0] corner_b_z;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [16:0] entry_time;
    } t_out;

    // One divider lane: |offset| << FRAC divided by |step|
    typedef struct packed {
        logic [31:0]       rem;     // partial remainder, below den unless ovf is set
        logic [31:0]       den;     // |step|
        logic [1:0]        nbits;   // low numerator bits still to shift in
        logic [QW_MAX-1:0] quo;     // quotient bits, filled from bit 0
        logic              neg;     // quotient sign
        logic              ovf;     // quotient too large, saturate
        logic              zs;      // step is zero
        logic              outside; // zero step with origin outside slab
    } t_lane;

    typedef t_lane t_lanes [NLANE];

endpackage

@@ hdl/rbst_prep.sv @@
// ----------------------------------------------------------------------------
// rbst_prep
// Front stage: corner offsets, magnitudes, divider setup per lane.
// ----------------------------------------------------------------------------
module rbst_prep (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbst_pkg::t_in   i_data,
    output rbst_pkg::t_lane o_lane [rbst_pkg::NLANE]
);

    logic signed [31:0] w_org  [rbst_pkg::NAXIS];
    logic signed [31:0] w_stp  [rbst_pkg::NAXIS];
    logic signed [31:0] w_ca   [rbst_pkg::NAXIS];
    logic signed [31:0] w_cb   [rbst_pkg::NAXIS];
    logic signed [32:0] w_da   [rbst_pkg::NAXIS];
    logic signed [32:0] w_db   [rbst_pkg::NAXIS];
    logic               w_out  [rbst_pkg::NAXIS];
    rbst_pkg::t_lane    n_lane [rbst_pkg::NLANE];
    rbst_pkg::t_lane    r_lane [rbst_pkg::NLANE];

    // Set up one lane from a 33-bit offset and the step
    function automatic rbst_pkg::t_lane f_setup(logic signed [32:0] d,
                                                logic signed [31:0] s,
                                                logic outside);
        rbst_pkg::t_lane l;
        logic [32:0]     ad;
        logic [31:0]     as;
        logic [30:0]     r0;
        ad        = d[32] ? 33'(-d) : 33'(d);
        as        = s[31] ? 32'(-s) : 32'(s);
        r0        = ad[32:2];
        l.rem     = {1'b0, r0};
        l.den     = as;
        l.nbits   = ad[1:0];
        l.quo     = '0;
        l.neg     = d[32] ^ s[31];
        l.ovf     = ({1'b0, r0} >= as);
        l.zs      = (s == 32'sd0);
        l.outside = outside;
        return l;
    endfunction

    assign w_org = '{i_data.origin_x, i_data.origin_y, i_data.origin_z};
    assign w_stp = '{i_data.step_x, i_data.step_y, i_data.step_z};
    assign w_ca  = '{i_data.corner_a_x, i_data.corner_a_y, i_data.corner_a_z};
    assign w_cb  = '{i_data.corner_b_x, i_data.corner_b_y, i_data.corner_b_z};

    // Offsets and per-axis outside test
    always_comb begin
        for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
            w_da[a]  = 33'(w_ca[a]) - 33'(w_org[a]);
            w_db[a]  = 33'(w_cb[a]) - 33'(w_org[a]);
            w_out[a] = ((w_da[a] > 0) && (w_db[a] > 0)) ||
                       ((w_da[a] < 0) && (w_db[a] < 0));
            n_lane[a]                   = f_setup(w_da[a], w_stp[a], w_out[a]);
            n_lane[a + rbst_pkg::NAXIS] = f_setup(w_db[a], w_stp[a], w_out[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ hdl/rbst_div_stage.sv @@
// ----------------------------------------------------------------------------
// rbst_div_stage
// One restoring division step for all six lanes, registered.
// ----------------------------------------------------------------------------
module rbst_div_stage (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbst_pkg::t_lane i_lane [rbst_pkg::NLANE],
    output rbst_pkg::t_lane o_lane [rbst_pkg::NLANE]
);

    rbst_pkg::t_lane n_lane [rbst_pkg::NLANE];
    rbst_pkg::t_lane r_lane [rbst_pkg::NLANE];

    // Shift in the next numerator bit, subtract if it fits
    always_comb begin
        logic [32:0] part;
        logic [32:0] diff;
        for (int l = 0; l < rbst_pkg::NLANE; l++) begin
            n_lane[l]       = i_lane[l];
            part            = {i_lane[l].rem, i_lane[l].nbits[1]};
            diff            = part - {1'b0, i_lane[l].den};
            n_lane[l].nbits = {i_lane[l].nbits[0], 1'b0};
            if (part >= {1'b0, i_lane[l].den}) begin
                n_lane[l].rem = diff[31:0];
                n_lane[l].quo = {i_lane[l].quo[rbst_pkg::QW_MAX-2:0], 1'b1};
            end else begin
                n_lane[l].rem = part[31:0];
                n_lane[l].quo = {i_lane[l].quo[rbst_pkg::QW_MAX-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ hdl/rbst_merge.sv @@
// ----------------------------------------------------------------------------
// rbst_merge
// Saturate quotients, per-axis intervals, then overall entry and hit.
// ----------------------------------------------------------------------------
module rbst_merge #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbst_pkg::t_lane i_lane [rbst_pkg::NLANE],
    output rbst_pkg::t_out  o_data
);

    localparam int QW = FRAC_BITS + 2;
    localparam int TW = QW + 1;
    localparam logic [QW-1:0]        CAP = QW'((1 << FRAC_BITS) + 1);
    localparam logic signed [TW-1:0] ONE = TW'(1 << FRAC_BITS);

    logic signed [TW-1:0] w_t    [rbst_pkg::NLANE];
    logic signed [TW-1:0] n_tmin [rbst_pkg::NAXIS];
    logic signed [TW-1:0] n_tmax [rbst_pkg::NAXIS];
    logic                 n_bad  [rbst_pkg::NAXIS];
    logic signed [TW-1:0] r_tmin [rbst_pkg::NAXIS];
    logic signed [TW-1:0] r_tmax [rbst_pkg::NAXIS];
    logic                 r_bad  [rbst_pkg::NAXIS];
    logic signed [TW-1:0] w_lo;
    logic signed [TW-1:0] w_hi;
    rbst_pkg::t_out       n_out;
    rbst_pkg::t_out       r_out;

    // Signed slab times, clamped to just outside [0,ONE]
    always_comb begin
        logic [QW-1:0] q;
        for (int l = 0; l < rbst_pkg::NLANE; l++) begin
            q = i_lane[l].quo[QW-1:0];
            if (i_lane[l].ovf || (q > CAP)) begin
                q = CAP;
            end
            w_t[l] = i_lane[l].neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        end
    end

    // Per-axis interval
    always_comb begin
        for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
            if (i_lane[a].zs) begin
                n_tmin[a] = '0;
                n_tmax[a] = ONE;
                n_bad[a]  = i_lane[a].outside;
            end else begin
                n_bad[a] = 1'b0;
                if (w_t[a] < w_t[a + rbst_pkg::NAXIS]) begin
                    n_tmin[a] = w_t[a];
                    n_tmax[a] = w_t[a + rbst_pkg::NAXIS];
                end else begin
                    n_tmin[a] = w_t[a + rbst_pkg::NAXIS];
                    n_tmax[a] = w_t[a];
                end
            end
        end
    end

    // Latest entry, earliest exit
    always_comb begin
        w_lo = '0;
        w_hi = ONE;
        for (int a = 0; a < rbst_pkg::NAXIS; a++) begin
            if (r_tmin[a] > w_lo) begin
                w_lo = r_tmin[a];
            end
            if (r_tmax[a] < w_hi) begin
                w_hi = r_tmax[a];
            end
        end
        n_out.hit        = !(r_bad[0] || r_bad[1] || r_bad[2]) && (w_lo <= w_hi);
        n_out.entry_time = n_out.hit ? 17'($unsigned(w_lo)) : 17'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            r_bad  <= n_bad;
            r_out  <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

@@ hdl/ray_box_slab_test.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Segment versus axis-aligned box, slab method, fully pipelined.
//
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+---------------------------
//  input    | i_valid  | o_ready  | i_data (rbst_pkg::t_in)
//  output   | o_valid  | i_ready  | o_data (rbst_pkg::t_out)
//
// One item per cycle while the output is not stalled; stages are one setup stage,
// FRAC_BITS + 2 division steps of six parallel lanes, interval and merge.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes every stage; o_ready is low only then.
// ----------------------------------------------------------------------------
module ray_box_slab_test #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rbst_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rbst_pkg::t_out o_data
);

    localparam int NDIV = FRAC_BITS + 2;
    localparam int NSTG = NDIV + 3;

    logic            w_en;
    logic [NSTG-1:0] r_vld;
    rbst_pkg::t_lane w_lane [NDIV+1][rbst_pkg::NLANE];

    // Whole pipe advances unless the result is held
    assign w_en    = !r_vld[NSTG-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[NSTG-1];

    // Valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    rbst_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (i_data),
        .o_lane (w_lane[0])
    );

    // Division steps, one quotient bit each
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        rbst_div_stage u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lane (w_lane[g]),
            .o_lane (w_lane[g+1])
        );
    end

    rbst_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_lane (w_lane[NDIV]),
        .o_data (o_data)
    );

endmodule

@@ bench/ray_box_slab_test_test.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test_test
// Self-checking bench for the ray segment versus box slab test. Items are
// driven through the valid/ready input channel, the expected hit and entry
// time are computed by an in-bench slab predictor, and every result is
// compared in order against the queue of expected results.
// ----------------------------------------------------------------------------
module ray_box_slab_test_test;

    localparam int FRAC      = rbst_pkg::FRAC_BITS_DEF;
    localparam int LATENCY   = FRAC + 5;
    localparam int WDOG_MAX  = 2000;
    localparam int N_RANDOM  = 1600;
    localparam int N_CALM    = 200;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, o_valid, i_ready;
    rbst_pkg::t_in  i_data;
    rbst_pkg::t_out o_data;

    rbst_pkg::t_out hit_queue[$];
    int   n_errors   = 0;
    int   n_sent     = 0;
    int   n_checked  = 0;
    int   n_hits     = 0;
    int   idle_cnt   = 0;
    bit   sink_calm  = 0;
    bit   src_calm   = 0;

    ray_box_slab_test #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Slab crossing time for one corner plane, saturated to 32 bits
    function automatic longint slab_cross(longint offset, longint step);
        longint q;
        q = (offset * (longint'(1) << FRAC)) / step;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    // Expected hit and entry time for one ray/box item
    function automatic rbst_pkg::t_out predict_slab(rbst_pkg::t_in it);
        longint org[3], stp[3], ca[3], cb[3];
        longint lo, hi, da, db, ta, tb;
        bit     ok;
        rbst_pkg::t_out r;
        org = '{it.origin_x, it.origin_y, it.origin_z};
        stp = '{it.step_x, it.step_y, it.step_z};
        ca  = '{it.corner_a_x, it.corner_a_y, it.corner_a_z};
        cb  = '{it.corner_b_x, it.corner_b_y, it.corner_b_z};
        lo = 0;
        hi = longint'(1) << FRAC;
        ok = 1;
        for (int ax = 0; ax < 3; ax++) begin
            da = ca[ax] - org[ax];
            db = cb[ax] - org[ax];
            if (stp[ax] == 0) begin
                // parallel axis: origin must lie inside the slab
                if ((da > 0 && db > 0) || (da < 0 && db < 0)) ok = 0;
            end else begin
                ta = slab_cross(da, stp[ax]);
                tb = slab_cross(db, stp[ax]);
                if ((ta < tb ? ta : tb) > lo) lo = (ta < tb ? ta : tb);
                if ((ta < tb ? tb : ta) < hi) hi = (ta < tb ? tb : ta);
            end
        end
        if (ok && lo > hi) ok = 0;
        r.hit        = ok;
        r.entry_time = ok ? lo[16:0] : '0;
        return r;
    endfunction

    // Send one item; payload and valid change at the falling edge only
    task automatic send_ray(rbst_pkg::t_in it);
        if (!src_calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_data  <= it;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        hit_queue.push_back(predict_slab(it));
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'sd0;
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    function automatic logic [31:0] rnd_step();
        case ($urandom_range(0, 6))
            0: return 32'sd0;
            1: return $urandom;
            2: return $signed($urandom_range(0, 3)) - 1;
            default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        endcase
    endfunction

    // Ray with random origin, step and box corners
    function automatic rbst_pkg::t_in aimed_ray();
        rbst_pkg::t_in it;
        it = '{default: rnd_coord()};
        it.origin_x = rnd_coord(); it.origin_y = rnd_coord(); it.origin_z = rnd_coord();
        it.step_x = rnd_step(); it.step_y = rnd_step(); it.step_z = rnd_step();
        it.corner_a_x = rnd_coord(); it.corner_a_y = rnd_coord();
        it.corner_a_z = rnd_coord(); it.corner_b_x = rnd_coord();
        it.corner_b_y = rnd_coord(); it.corner_b_z = rnd_coord();
        return it;
    endfunction

    // Result sink with random stalls
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            if (!sink_calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1;
            end
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready))) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result hit=%0b entry=%0h", $realtime,
                         o_data.hit, o_data.entry_time);
                n_errors++;
            end else begin
                rbst_pkg::t_out exp_r;
                exp_r = hit_queue.pop_front();
                if (o_data.hit !== exp_r.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $realtime,
                             exp_r.hit, o_data.hit);
                    n_errors++;
                end
                if (o_data.entry_time !== exp_r.entry_time) begin
                    $display("%0t: entry_time expected %0h actual %0h", $realtime,
                             exp_r.entry_time, o_data.entry_time);
                    n_errors++;
                end
                n_checked++;
                if (exp_r.hit) n_hits++;
            end
        end
        if (idle_cnt >= WDOG_MAX) begin
            $display("%0t: watchdog timeout", $realtime);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic rbst_pkg::t_in unit_box(logic [31:0] ox, logic [31:0] sx);
        rbst_pkg::t_in it;
        it = '0;
        it.origin_x = ox; it.step_x = sx;
        it.origin_y = 32'sd0; it.origin_z = 32'sd0;
        it.corner_a_x = 32'sd0; it.corner_b_x = 32'sd65536;
        it.corner_a_y = -32'sd65536; it.corner_b_y = 32'sd65536;
        it.corner_a_z = -32'sd65536; it.corner_b_z = 32'sd65536;
        return it;
    endfunction

    // Corners, parallel axes, touching and saturation cases
    task automatic test_directed();
        rbst_pkg::t_in it;
        send_ray('0);                                  // degenerate box at origin
        send_ray('1);                                  // all fields -1
        it = '{default: 32'h7FFF_FFFF}; send_ray(it);
        it = '{default: 32'h8000_0000}; send_ray(it);
        send_ray(unit_box(-32'sd65536, 32'sd131072));  // enters at t=0.5
        send_ray(unit_box(32'sd131072, -32'sd131072)); // reversed direction
        send_ray(unit_box(-32'sd65536, 32'sd65536));   // touches at t=1
        send_ray(unit_box(-32'sd131072, 32'sd65536));  // falls short
        send_ray(unit_box(32'sd32768, 32'sd0));        // parallel, inside
        send_ray(unit_box(32'sd0, 32'sd0));            // parallel, on face
        send_ray(unit_box(32'sd131072, 32'sd0));       // parallel, outside +
        send_ray(unit_box(-32'sd1, 32'sd0));           // parallel, outside -
        send_ray(unit_box(32'h8000_0000, 32'sd1));     // huge quotient
        send_ray(unit_box(32'h8000_0000, 32'h7FFF_FFFF));
        send_ray(unit_box(32'sd32768, 32'h8000_0000));
        it = unit_box(32'sd32768, 32'sd1);
        it.corner_a_x = 32'h7FFF_FFFF; it.corner_b_x = 32'h8000_0000;
        send_ray(it);                                  // box spans full range
        it = unit_box(-32'sd65536, 32'sd131072);
        it.step_y = 32'sd65536; it.origin_y = -32'sd131072;
        send_ray(it);                                  // two axes, lo==hi
    endtask

    task automatic test_random();
        for (int k = 0; k < N_RANDOM; k++) send_ray(aimed_ray());
    endtask

    // Back to back with the sink always ready
    task automatic test_full_rate();
        src_calm = 1;
        sink_calm = 1;
        for (int k = 0; k < N_CALM; k++) begin
            i_data  <= aimed_ray();
            i_valid <= 1;
            do @(posedge i_clk); while (!o_ready);
            hit_queue.push_back(predict_slab(i_data));
            n_sent++;
            @(negedge i_clk);
        end
        i_valid <= 0;
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_directed();
        test_random();
        test_full_rate();
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Checked %0d of %0d rays (%0d hits), directed, random and full rate.",
                 n_checked, n_sent, n_hits);
        if (n_errors == 0 && hit_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
